/* design/cpr_pkg.sv */
// Shared types and codes for the clock page replacer.
// No dependencies; imported by clock_page_replacer.
`default_nettype none

package cpr_pkg;

   localparam int unsigned NUM_FRAMES_DEF = 64;

   localparam int unsigned FUNC_W   = 2;
   localparam int unsigned FRAME_W  = 6;
   localparam int unsigned COUNT_W  = 7;
   localparam int unsigned STATUS_W = 2;

   // request operation codes
   localparam logic [FUNC_W-1:0] FUNC_VICTIM = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_PIN    = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_UNPIN  = 2'd2;

   // per-frame status codes
   localparam logic [STATUS_W-1:0] STAT_PINNED    = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_ACCESSED  = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_UNTOUCHED = 2'd2;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EVAL
   } state_type;

endpackage

`default_nettype wire

/* design/cpr_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies; used by clock_page_replacer for the frame status table.
`default_nettype none

module cpr_ram #(
   parameter int unsigned WIDTH = 2,
   parameter int unsigned DEPTH = 64,
   localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AddrW-1:0] waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic             re,
   input  wire logic [AddrW-1:0] raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

/* design/clock_page_replacer.sv */
// Clock page replacer: status table in RAM, clock hand, evictable count.
// Depends on cpr_pkg and cpr_ram.
//
//   channel | direction | ports
//   req     | in        | req_valid, req_ready, req_func, req_frame
//   rsp     | out       | rsp_valid, rsp_ready, rsp_found, rsp_victim_frame,
//           |           | rsp_evictable_count
//
// Pin, unpin and unknown operations read the status RAM, then evaluate and write
// back. A victim request reads the slot under the hand, then each slot the hand
// passes (at most 2*NUM_FRAMES slots), one RAM read-modify-write per slot.
// After reset a clearing pass writes every entry with req_ready low. One
// transaction is in flight at a time; a new request is taken while a result
// waits in the output register, and the final write-back stalls only if that
// register is still full.
`default_nettype none

module clock_page_replacer import cpr_pkg::*; #(
   parameter int unsigned NUM_FRAMES = NUM_FRAMES_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [FUNC_W-1:0]  req_func,
   input  wire logic [FRAME_W-1:0] req_frame,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic                    rsp_found,
   output logic      [FRAME_W-1:0] rsp_victim_frame,
   output logic      [COUNT_W-1:0] rsp_evictable_count
);

   localparam int unsigned AW = $clog2(NUM_FRAMES);
   localparam int unsigned TW = $clog2(NUM_FRAMES + 1);
   localparam logic [AW-1:0] LAST = AW'(NUM_FRAMES - 1);

   state_type state_ff, state_in;
   logic [AW-1:0]     hand_ff, hand_in, hand_nxt;
   logic [TW-1:0]     total_ff, total_in;
   logic [FUNC_W-1:0] op_ff, op_in;
   logic [AW-1:0]     addr_ff, addr_in;
   logic              rng_ff, rng_in;
   logic [AW-1:0]     clr_ff, clr_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_found_ff, rsp_found_in;
   logic [FRAME_W-1:0] rsp_victim_ff, rsp_victim_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic                ram_we, ram_re;
   logic [AW-1:0]       ram_waddr, ram_raddr;
   logic [STATUS_W-1:0] ram_wdata, ram_rdata;

   logic out_free, finish, fin_found;

   cpr_ram #(
      .WIDTH(STATUS_W),
      .DEPTH(NUM_FRAMES)
   ) u_status (
      .clock(clock),
      .we   (ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .re   (ram_re),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign hand_nxt = (hand_ff == LAST) ? '0 : hand_ff + AW'(1);

   always_comb begin
      state_in     = state_ff;
      hand_in      = hand_ff;
      total_in     = total_ff;
      op_in        = op_ff;
      addr_in      = addr_ff;
      rng_in       = rng_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_found_in = rsp_found_ff;
      rsp_victim_in = rsp_victim_ff;
      rsp_count_in = rsp_count_ff;
      ram_we       = 1'b0;
      ram_waddr    = addr_ff;
      ram_wdata    = STAT_PINNED;
      ram_re       = 1'b0;
      ram_raddr    = addr_ff;
      req_ready    = 1'b0;
      finish       = 1'b0;
      fin_found    = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            clr_in    = clr_ff + AW'(1);
            if (clr_ff == LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in     = req_func;
               rng_in    = 32'(req_frame) < NUM_FRAMES;
               addr_in   = (req_func == FUNC_VICTIM) ? hand_ff : AW'(req_frame);
               ram_re    = 1'b1;
               ram_raddr = addr_in;
               state_in  = ST_EVAL;
            end
         end
         ST_EVAL: begin
            unique case (op_ff)
               FUNC_VICTIM: begin
                  if (total_ff == '0) begin
                     finish = out_free;
                  end else if (ram_rdata == STAT_UNTOUCHED) begin
                     // victim found: hand stays on this slot
                     if (out_free) begin
                        ram_we    = 1'b1;
                        ram_waddr = hand_ff;
                        ram_wdata = STAT_PINNED;
                        total_in  = total_ff - TW'(1);
                        finish    = 1'b1;
                        fin_found = 1'b1;
                     end
                  end else begin
                     // age an accessed frame, skip a pinned one, read the next slot
                     if (ram_rdata == STAT_ACCESSED) begin
                        ram_we    = 1'b1;
                        ram_waddr = hand_ff;
                        ram_wdata = STAT_UNTOUCHED;
                     end
                     hand_in   = hand_nxt;
                     ram_re    = 1'b1;
                     ram_raddr = hand_nxt;
                  end
               end
               FUNC_PIN: begin
                  if (out_free) begin
                     finish = 1'b1;
                     if (rng_ff) begin
                        ram_we    = 1'b1;
                        ram_wdata = STAT_PINNED;
                        if (ram_rdata != STAT_PINNED && total_ff != '0) begin
                           total_in = total_ff - TW'(1);
                        end
                     end
                  end
               end
               FUNC_UNPIN: begin
                  if (out_free) begin
                     finish = 1'b1;
                     if (rng_ff && ram_rdata == STAT_PINNED) begin
                        ram_we    = 1'b1;
                        ram_wdata = STAT_ACCESSED;
                        total_in  = total_ff + TW'(1);
                     end
                  end
               end
               default: begin
                  finish = out_free;
               end
            endcase
            if (finish) begin
               rsp_valid_in  = 1'b1;
               rsp_found_in  = fin_found;
               rsp_victim_in = fin_found ? FRAME_W'(hand_ff) : '0;
               rsp_count_in  = COUNT_W'(total_in);
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         hand_ff      <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         hand_ff      <= hand_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      addr_ff       <= addr_in;
      rng_ff        <= rng_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_victim_ff <= rsp_victim_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_found           = rsp_found_ff;
   assign rsp_victim_frame    = rsp_victim_ff;
   assign rsp_evictable_count = rsp_count_ff;

`ifndef NO_ASSERTIONS
   a_no_req_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !req_ready)
      else $error("request taken during clearing pass");

   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      32'(total_ff) <= NUM_FRAMES)
      else $error("evictable count exceeds frame count");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff != ST_IDLE))
      else $error("status write while idle");

   a_no_rw_same_addr: assert property (@(posedge clock) disable iff (reset)
      (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
      else $error("status read and write hit the same entry");

   a_found_drops_count: assert property (@(posedge clock) disable iff (reset)
      (finish && fin_found) |=> (total_ff == $past(total_ff) - TW'(1)))
      else $error("victim eviction did not decrement count");
`endif

endmodule

`default_nettype wire

/* verif/testbench.sv */
// Self-checking testbench for clock_page_replacer: queue-fed driver, monitor with a shadow
// replacer that predicts every result. Depends on cpr_pkg and the design sources.
module testbench import cpr_pkg::*; ();

   localparam int unsigned FRAMES      = NUM_FRAMES_DEF;
   localparam int unsigned SWEEP_LIMIT = 2 * FRAMES + 1;
   localparam int unsigned DRAIN_WAIT  = 2 * FRAMES + 8;
   localparam int unsigned CYCLE_LIMIT = 1000000;
   localparam int unsigned RANDOM_REQS = 1550;
   localparam logic [FUNC_W-1:0] FUNC_UNKNOWN = 2'd3;

   typedef struct {
      logic [FUNC_W-1:0]  func;
      logic [FRAME_W-1:0] frame;
      int unsigned        gap;
      bit                 drain;
   } request_type;

   typedef struct {
      logic               found;
      logic [FRAME_W-1:0] victim_frame;
      logic [COUNT_W-1:0] evictable_count;
   } outcome_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [FUNC_W-1:0]  req_func = '0;
   logic [FRAME_W-1:0] req_frame = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic               rsp_found;
   logic [FRAME_W-1:0] rsp_victim_frame;
   logic [COUNT_W-1:0] rsp_evictable_count;

   clock_page_replacer #(.NUM_FRAMES(FRAMES)) u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_func            (req_func),
      .req_frame           (req_frame),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_found           (rsp_found),
      .rsp_victim_frame    (rsp_victim_frame),
      .rsp_evictable_count (rsp_evictable_count)
   );

   always #5 clock = ~clock;

   // shadow replacer state
   logic [STATUS_W-1:0] shadow_status [FRAMES];
   logic [FRAME_W-1:0]  shadow_hand;
   logic [COUNT_W-1:0]  shadow_evictable;

   request_type request_queue [$];
   outcome_type expected_outcomes [$];
   int unsigned error_count = 0;
   int unsigned results_checked = 0;
   int unsigned victim_reqs = 0, pin_reqs = 0, unpin_reqs = 0, unknown_reqs = 0;
   int unsigned victims_found = 0, victims_empty = 0, longest_sweep = 0;

   task automatic report_mismatch(input string what);
      if (error_count < 40)
         $display("mismatch at %0t: %s", $time, what);
      error_count++;
   endtask

   // Apply one accepted request to the shadow state and queue the result it must produce.
   task automatic track_request(input logic [FUNC_W-1:0] func,
                                input logic [FRAME_W-1:0] frame);
      outcome_type exp;
      int unsigned steps;
      int unsigned slot;
      exp.found = 1'b0;
      exp.victim_frame = '0;
      steps = 0;
      case (func)
         FUNC_VICTIM: begin
            victim_reqs++;
            if (shadow_evictable != 0) begin
               while (!exp.found && steps < SWEEP_LIMIT) begin
                  slot = 32'(shadow_hand);
                  if (shadow_status[slot] == STAT_ACCESSED) begin
                     shadow_status[slot] = STAT_UNTOUCHED;
                  end else if (shadow_status[slot] == STAT_UNTOUCHED) begin
                     shadow_status[slot] = STAT_PINNED;
                     shadow_evictable = shadow_evictable - COUNT_W'(1);
                     exp.found = 1'b1;
                     exp.victim_frame = slot[FRAME_W-1:0];
                  end
                  // hand stays on the victim's slot
                  if (!exp.found)
                     shadow_hand = FRAME_W'((slot + 1) % FRAMES);
                  steps++;
               end
            end
            if (exp.found)
               victims_found++;
            else
               victims_empty++;
            if (steps > longest_sweep)
               longest_sweep = steps;
         end
         FUNC_PIN: begin
            pin_reqs++;
            if (shadow_status[frame] != STAT_PINNED && shadow_evictable != 0)
               shadow_evictable = shadow_evictable - COUNT_W'(1);
            shadow_status[frame] = STAT_PINNED;
         end
         FUNC_UNPIN: begin
            unpin_reqs++;
            if (shadow_status[frame] == STAT_PINNED) begin
               shadow_status[frame] = STAT_ACCESSED;
               shadow_evictable = shadow_evictable + COUNT_W'(1);
            end
         end
         default: begin
            unknown_reqs++;
         end
      endcase
      exp.evictable_count = shadow_evictable;
      expected_outcomes.push_back(exp);
   endtask

   // driver
   request_type staged;
   bit          staged_ok = 1'b0;
   int unsigned gap_left = 0;
   int unsigned sent_count = 0, back_count = 0;
   logic        drv_next_valid;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         drv_next_valid = req_valid;
         if (rsp_valid && rsp_ready)
            back_count++;
         if (req_valid && req_ready) begin
            sent_count++;
            drv_next_valid = 1'b0;
         end
         if (!drv_next_valid) begin
            if (!staged_ok && request_queue.size() > 0) begin
               staged = request_queue.pop_front();
               staged_ok = 1'b1;
               gap_left = staged.gap;
            end
            if (staged_ok) begin
               if (gap_left > 0) begin
                  gap_left--;
               end else if (!staged.drain || sent_count == back_count) begin
                  req_func <= staged.func;
                  req_frame <= staged.frame;
                  drv_next_valid = 1'b1;
                  staged_ok = 1'b0;
               end
            end
         end
         req_valid <= drv_next_valid;
      end
   end

   // monitor
   int unsigned stall_left = 0;
   logic        mon_next_ready;
   outcome_type head;
   int unsigned init_idx;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = $urandom_range(0, 8);
         for (init_idx = 0; init_idx < FRAMES; init_idx++)
            shadow_status[init_idx] = STAT_PINNED;
         shadow_hand = '0;
         shadow_evictable = '0;
      end else begin
         mon_next_ready = rsp_ready;
         if (req_valid && req_ready)
            track_request(req_func, req_frame);
         if (rsp_valid && rsp_ready) begin
            if (expected_outcomes.size() == 0) begin
               report_mismatch($sformatf("unexpected result found=%0d victim=%0d count=%0d",
                  rsp_found, rsp_victim_frame, rsp_evictable_count));
            end else begin
               head = expected_outcomes.pop_front();
               if (rsp_found !== head.found)
                  report_mismatch($sformatf("found %0d, expected %0d",
                     rsp_found, head.found));
               if (rsp_victim_frame !== head.victim_frame)
                  report_mismatch($sformatf("victim_frame %0d, expected %0d",
                     rsp_victim_frame, head.victim_frame));
               if (rsp_evictable_count !== head.evictable_count)
                  report_mismatch($sformatf("evictable_count %0d, expected %0d",
                     rsp_evictable_count, head.evictable_count));
            end
            results_checked++;
            // every third window of 128 results runs without stalls
            if ((results_checked / 128) % 3 == 1)
               stall_left = 0;
            else
               stall_left = $urandom_range(0, 8);
            mon_next_ready = (stall_left == 0);
         end else if (!rsp_ready) begin
            if (stall_left > 0)
               stall_left--;
            mon_next_ready = (stall_left == 0);
         end
         rsp_ready <= mon_next_ready;
      end
   end

   task automatic queue_request(input logic [FUNC_W-1:0] func, input logic [FRAME_W-1:0] frame,
                                input int unsigned gap, input bit drain);
      request_type item;
      item.func = func;
      item.frame = frame;
      item.gap = gap;
      item.drain = drain;
      request_queue.push_back(item);
   endtask

   // stimulus and end of run
   initial begin
      int unsigned        i;
      int unsigned        pick;
      int unsigned        victim_pct;
      bit                 narrow;
      bit                 no_gaps;
      logic [FRAME_W-1:0] base;
      logic [FUNC_W-1:0]  func;
      logic [FRAME_W-1:0] frame;

      // directed: empty victim, unknown op, repeats, full wrap, long sweep back to the hand
      queue_request(FUNC_VICTIM,  6'd0,  $urandom_range(0, 8), 1'b0);
      queue_request(FUNC_UNKNOWN, 6'd63, $urandom_range(0, 8), 1'b0);
      queue_request(FUNC_PIN,     6'd0,  $urandom_range(0, 8), 1'b0);
      queue_request(FUNC_UNPIN,   6'd0,  $urandom_range(0, 8), 1'b0);
      queue_request(FUNC_UNPIN,   6'd63, $urandom_range(0, 8), 1'b0);
      queue_request(FUNC_UNPIN,   6'd0,  $urandom_range(0, 8), 1'b0);
      queue_request(FUNC_UNKNOWN, 6'd0,  $urandom_range(0, 8), 1'b0);
      queue_request(FUNC_VICTIM,  6'd63, $urandom_range(0, 8), 1'b0);
      queue_request(FUNC_VICTIM,  6'd0,  $urandom_range(0, 8), 1'b0);
      queue_request(FUNC_UNPIN,   6'd5,  $urandom_range(0, 8), 1'b0);
      queue_request(FUNC_PIN,     6'd5,  $urandom_range(0, 8), 1'b0);
      queue_request(FUNC_UNPIN,   6'd10, $urandom_range(0, 8), 1'b0);
      queue_request(FUNC_VICTIM,  6'd42, $urandom_range(0, 8), 1'b0);
      queue_request(FUNC_UNPIN,   6'd42, $urandom_range(0, 8), 1'b0);
      queue_request(FUNC_UNPIN,   6'd21, $urandom_range(0, 8), 1'b0);
      queue_request(FUNC_VICTIM,  6'd21, $urandom_range(0, 8), 1'b0);
      queue_request(FUNC_VICTIM,  6'd0,  $urandom_range(0, 8), 1'b0);
      queue_request(FUNC_VICTIM,  6'd0,  $urandom_range(0, 8), 1'b0);
      queue_request(FUNC_PIN,     6'd63, $urandom_range(0, 8), 1'b0);
      queue_request(FUNC_UNPIN,   6'd7,  $urandom_range(0, 8), 1'b0);
      queue_request(FUNC_UNKNOWN, 6'd7,  $urandom_range(0, 8), 1'b0);
      queue_request(FUNC_PIN,     6'd7,  $urandom_range(0, 8), 1'b0);

      narrow = 1'b0;
      no_gaps = 1'b0;
      base = '0;
      victim_pct = 30;
      for (i = 0; i < RANDOM_REQS; i++) begin
         // pick a new traffic style every 50 transactions
         if (i % 50 == 0) begin
            narrow = ($urandom_range(0, 2) == 0);
            base = FRAME_W'($urandom_range(0, 63));
            no_gaps = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 2))
               0: victim_pct = 10;
               1: victim_pct = 30;
               default: victim_pct = 50;
            endcase
         end
         pick = $urandom_range(0, 99);
         if (pick < 3)
            func = FUNC_UNKNOWN;
         else if (pick < 3 + victim_pct)
            func = FUNC_VICTIM;
         else if ($urandom_range(0, 99) < 60)
            func = FUNC_UNPIN;
         else
            func = FUNC_PIN;
         if (narrow)
            frame = base + 6'($urandom_range(0, 7));
         else
            frame = FRAME_W'($urandom_range(0, 63));
         queue_request(func, frame, no_gaps ? 0 : $urandom_range(0, 8), (i % 400) == 0);
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (request_queue.size() != 0 || staged_ok || req_valid)
         @(posedge clock);
      while (expected_outcomes.size() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("Covered %0d requests: %0d victim, %0d pin, %0d unpin, %0d unknown;",
         victim_reqs + pin_reqs + unpin_reqs + unknown_reqs, victim_reqs, pin_reqs,
         unpin_reqs, unknown_reqs);
      $display("%0d results checked, %0d victims found, %0d victim requests empty, %s %0d slots.",
         results_checked, victims_found, victims_empty, "longest sweep", longest_sweep);
      if (error_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   initial begin
      #(CYCLE_LIMIT * 10);
      $display("timeout after %0d cycles, %0d results still expected",
         CYCLE_LIMIT, expected_outcomes.size());
      $display("FAILURE");
      $finish;
   end

endmodule

/* clock_page_replacer.f */
design/cpr_pkg.sv
design/cpr_ram.sv
design/clock_page_replacer.sv
verif/testbench.sv
